FILE: rtl/xrg_pkg.sv
// xrg_pkg: constants, datapath op codes and control/status types for the
// xoshiro256** generator. No dependencies.
`default_nettype none
package xrg_pkg;
    localparam logic [63:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;

    localparam logic [1:0] KIND_BOUNDED = 2'd1;
    localparam logic [1:0] KIND_UNIT    = 2'd2;

    localparam logic [4:0] DP_NOP      = 5'd0;
    localparam logic [4:0] DP_SEED     = 5'd1;
    localparam logic [4:0] DP_INC      = 5'd2;
    localparam logic [4:0] DP_XS30     = 5'd3;
    localparam logic [4:0] DP_XS27     = 5'd4;
    localparam logic [4:0] DP_MUL0     = 5'd5;
    localparam logic [4:0] DP_MUL1     = 5'd6;
    localparam logic [4:0] DP_MUL2     = 5'd7;
    localparam logic [4:0] DP_PUSH     = 5'd8;
    localparam logic [4:0] DP_TAKE     = 5'd9;
    localparam logic [4:0] DP_ADV      = 5'd10;
    localparam logic [4:0] DP_OUT      = 5'd11;
    localparam logic [4:0] DP_THR_INIT = 5'd12;
    localparam logic [4:0] DP_DIV_STEP = 5'd13;
    localparam logic [4:0] DP_THR_SAVE = 5'd14;
    localparam logic [4:0] DP_MOD_INIT = 5'd15;
    localparam logic [4:0] DP_RES_RAW  = 5'd16;
    localparam logic [4:0] DP_RES_UNIT = 5'd17;
    localparam logic [4:0] DP_RES_REM  = 5'd18;
    localparam logic [4:0] DP_RES_ZERO = 5'd19;

    typedef struct packed {
        logic [4:0] op;
        logic       csel;   // 0: MIX_MUL_A, 1: MIX_MUL_B
    } t_cmd;

    typedef struct packed {
        logic x_ge_thr;
        logic bound_zero;
    } t_stat;
endpackage
`default_nettype wire

FILE: rtl/xrg_req_if.sv
// xrg_req_if: request channel (kind, bound) with valid/ready.
// No dependencies.
`default_nettype none
interface xrg_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] bound;
    modport source (output valid, output kind, output bound, input ready);
    modport sink   (input valid, input kind, input bound, output ready);
endinterface
`default_nettype wire

FILE: rtl/xrg_rsp_if.sv
// xrg_rsp_if: result channel (value) with valid/ready.
// No dependencies.
`default_nettype none
interface xrg_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

FILE: rtl/xrg_datapath.sv
// xrg_datapath: generator state, splitmix64 seeding with a shared 32x32
// multiplier, output scrambler and bit-serial remainder unit. Uses xrg_pkg.
`default_nettype none
module xrg_datapath import xrg_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_seed_we,
    input  wire logic [63:0] i_seed,
    input  wire logic [63:0] i_bound,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    output logic [63:0]      o_value
);
    logic [63:0] r_seed, r_ctr, r_z, r_acc, r_x, r_bound, r_rem, r_dvd, r_thr, r_res;
    logic [63:0] r_s0, r_s1, r_s2, r_s3;
    logic [63:0] mc, ctr_inc, t2, t3, rot, rot_x;
    logic [31:0] m_a, m_b;
    logic [63:0] prod, acc_sum;
    logic [64:0] trial, trial_sub;

    assign mc      = i_cmd.csel ? MIX_MUL_B : MIX_MUL_A;
    assign m_a     = (i_cmd.op == DP_MUL2) ? r_z[63:32] : r_z[31:0];
    assign m_b     = (i_cmd.op == DP_MUL1) ? mc[63:32] : mc[31:0];
    assign prod    = m_a * m_b;
    assign acc_sum = r_acc + {prod[31:0], 32'h0};
    assign ctr_inc = r_ctr + GOLDEN_INC;
    assign t2      = r_s2 ^ r_s0;
    assign t3      = r_s3 ^ r_s1;
    assign rot     = {r_acc[56:0], r_acc[63:57]};
    assign rot_x   = rot + {rot[60:0], 3'b000};
    assign trial     = {r_rem, r_dvd[63]};
    assign trial_sub = trial - {1'b0, r_bound};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 64'h0;
        end else if (i_seed_we) begin
            r_seed <= i_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_SEED:  r_ctr <= r_seed;
            DP_INC: begin
                r_ctr <= ctr_inc;
                r_z   <= ctr_inc;
            end
            DP_XS30:  r_z   <= r_z ^ (r_z >> 30);
            DP_XS27:  r_z   <= r_z ^ (r_z >> 27);
            DP_MUL0:  r_acc <= prod;
            DP_MUL1:  r_acc <= acc_sum;
            DP_MUL2:  r_z   <= acc_sum;
            DP_PUSH: begin
                r_s0 <= r_s1;
                r_s1 <= r_s2;
                r_s2 <= r_s3;
                r_s3 <= r_z ^ (r_z >> 31);
            end
            DP_TAKE:  r_bound <= i_bound;
            DP_ADV: begin
                r_acc <= r_s1 + {r_s1[61:0], 2'b00};
                r_s2  <= t2 ^ {r_s1[46:0], 17'h0};
                r_s3  <= {t3[18:0], t3[63:19]};
                r_s1  <= r_s1 ^ t2;
                r_s0  <= r_s0 ^ t3;
            end
            DP_OUT:   r_x <= rot_x;
            DP_THR_INIT: begin
                r_rem <= 64'h0;
                r_dvd <= 64'h0 - r_bound;
            end
            DP_DIV_STEP: begin
                r_rem <= trial_sub[64] ? trial[63:0] : trial_sub[63:0];
                r_dvd <= {r_dvd[62:0], 1'b0};
            end
            DP_THR_SAVE: r_thr <= r_rem;
            DP_MOD_INIT: begin
                r_rem <= 64'h0;
                r_dvd <= r_x;
            end
            DP_RES_RAW:  r_res <= r_x;
            DP_RES_UNIT: r_res <= {11'h0, r_x[63:11]};
            DP_RES_REM:  r_res <= r_rem;
            DP_RES_ZERO: r_res <= 64'h0;
            default: ;
        endcase
    end

    assign o_stat.x_ge_thr   = (r_x >= r_thr);
    assign o_stat.bound_zero = (r_bound == 64'h0);
    assign o_value           = r_res;
endmodule
`default_nettype wire

FILE: rtl/xrg_ctrl.sv
// xrg_ctrl: sequencer for seeding, draws, rejection and remainder steps,
// plus the result valid flag. Uses xrg_pkg.
`default_nettype none
module xrg_ctrl import xrg_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_seed_we,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_in_kind,
    input  wire logic       i_out_ready,
    input  wire t_stat      i_stat,
    output t_cmd            o_cmd,
    output logic            o_in_ready,
    output logic            o_out_valid
);
    localparam logic [4:0] S_SEED = 5'd0,  S_INC = 5'd1,  S_XS30 = 5'd2, S_MA0 = 5'd3,
                           S_MA1 = 5'd4,   S_MA2 = 5'd5,  S_XS27 = 5'd6, S_MB0 = 5'd7,
                           S_MB1 = 5'd8,   S_MB2 = 5'd9,  S_PUSH = 5'd10, S_IDLE = 5'd11,
                           S_DEC = 5'd12,  S_THRI = 5'd13, S_THRD = 5'd14, S_THRS = 5'd15,
                           S_ADV = 5'd16,  S_OUT = 5'd17, S_CHK = 5'd18, S_MODI = 5'd19,
                           S_MODD = 5'd20, S_FIN = 5'd21;

    logic [4:0] r_st, n_st;
    logic [5:0] r_cnt, n_cnt;
    logic [1:0] r_w, n_w, r_kind, n_kind;
    logic       r_ovalid, n_ovalid;
    logic       accept;

    assign accept      = (r_st == S_IDLE) && i_in_valid;
    assign o_in_ready  = (r_st == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_st      = r_st;
        n_cnt     = r_cnt;
        n_w       = r_w;
        n_kind    = r_kind;
        n_ovalid  = r_ovalid && !i_out_ready;
        o_cmd.op  = DP_NOP;
        o_cmd.csel = 1'b0;
        unique case (r_st)
            S_SEED: begin
                o_cmd.op = DP_SEED;
                n_w  = 2'd0;
                n_st = S_INC;
            end
            S_INC:  begin o_cmd.op = DP_INC;  n_st = S_XS30; end
            S_XS30: begin o_cmd.op = DP_XS30; n_st = S_MA0; end
            S_MA0:  begin o_cmd.op = DP_MUL0; n_st = S_MA1; end
            S_MA1:  begin o_cmd.op = DP_MUL1; n_st = S_MA2; end
            S_MA2:  begin o_cmd.op = DP_MUL2; n_st = S_XS27; end
            S_XS27: begin o_cmd.op = DP_XS27; n_st = S_MB0; end
            S_MB0:  begin o_cmd.op = DP_MUL0; o_cmd.csel = 1'b1; n_st = S_MB1; end
            S_MB1:  begin o_cmd.op = DP_MUL1; o_cmd.csel = 1'b1; n_st = S_MB2; end
            S_MB2:  begin o_cmd.op = DP_MUL2; o_cmd.csel = 1'b1; n_st = S_PUSH; end
            S_PUSH: begin
                o_cmd.op = DP_PUSH;
                n_w  = r_w + 2'd1;
                n_st = (r_w == 2'd3) ? S_IDLE : S_INC;
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.op = DP_TAKE;
                    n_kind   = i_in_kind;
                    n_st     = S_DEC;
                end
            end
            S_DEC: begin
                if (r_kind != KIND_BOUNDED) begin
                    n_st = S_ADV;
                end else if (i_stat.bound_zero) begin
                    n_st = S_FIN;
                end else begin
                    n_st = S_THRI;
                end
            end
            S_THRI: begin
                o_cmd.op = DP_THR_INIT;
                n_cnt = 6'd0;
                n_st  = S_THRD;
            end
            S_THRD: begin
                o_cmd.op = DP_DIV_STEP;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_st = S_THRS;
                end
            end
            S_THRS: begin o_cmd.op = DP_THR_SAVE; n_st = S_ADV; end
            S_ADV:  begin o_cmd.op = DP_ADV; n_st = S_OUT; end
            S_OUT: begin
                o_cmd.op = DP_OUT;
                n_st = (r_kind == KIND_BOUNDED) ? S_CHK : S_FIN;
            end
            S_CHK: n_st = i_stat.x_ge_thr ? S_MODI : S_ADV;
            S_MODI: begin
                o_cmd.op = DP_MOD_INIT;
                n_cnt = 6'd0;
                n_st  = S_MODD;
            end
            S_MODD: begin
                o_cmd.op = DP_DIV_STEP;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_st = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ovalid || i_out_ready) begin
                    case (r_kind)
                        KIND_BOUNDED: o_cmd.op = i_stat.bound_zero ? DP_RES_ZERO : DP_RES_REM;
                        KIND_UNIT:    o_cmd.op = DP_RES_UNIT;
                        default:      o_cmd.op = DP_RES_RAW;
                    endcase
                    n_ovalid = 1'b1;
                    n_st     = S_IDLE;
                end
            end
            default: n_st = S_SEED;
        endcase
        if (i_seed_we) begin
            n_st = S_SEED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_SEED;
            r_cnt    <= 6'd0;
            r_w      <= 2'd0;
            r_kind   <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_cnt    <= n_cnt;
            r_w      <= n_w;
            r_kind   <= n_kind;
            r_ovalid <= n_ovalid;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/xoshiro256ss_random_generator.sv
// xoshiro256** generator, one 64-bit result per request: raw draw, unbiased
// bounded draw or 53-bit unit fraction. After reset and after each seed write
// the state is rebuilt by splitmix64 seeding, during which no request is taken.
// A raw or unit request passes decode, a state advance and the output scrambler;
// a bounded request adds two passes of the one-bit-per-cycle remainder unit
// (threshold, then reduction) and a fresh draw per rejected draw. A bound of
// zero returns 0 and draws nothing. The result register frees the request
// side: a new request is taken while a result waits.
// Depends on xrg_pkg, xrg_req_if, xrg_rsp_if, xrg_ctrl, xrg_datapath.
`default_nettype none
module xoshiro256ss_random_generator import xrg_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_seed_we,
    input  wire logic [63:0] i_seed,
    xrg_req_if.sink          i_req,
    xrg_rsp_if.source        o_rsp
);
    t_cmd  cmd;
    t_stat stat;
    logic  in_ready, out_valid;
    logic [63:0] value;

    xrg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed_we   (i_seed_we),
        .i_in_valid  (i_req.valid),
        .i_in_kind   (i_req.kind),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid)
    );

    xrg_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seed_we (i_seed_we),
        .i_seed    (i_seed),
        .i_bound   (i_req.bound),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_value   (value)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
    assign o_rsp.value = value;
endmodule
`default_nettype wire

FILE: rtl/xrg_checker.sv
// xrg_checker: port-level assertions for the generator, bound to the top level.
// Depends on xoshiro256ss_random_generator.
`default_nettype none
module xrg_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_seed_we,
    input wire logic        i_req_valid,
    input wire logic        i_req_ready,
    input wire logic        i_rsp_valid,
    input wire logic        i_rsp_ready,
    input wire logic [63:0] i_rsp_value
);
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result dropped before transfer");
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_value))
        else $error("stalled result changed");
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");
    a_reseed_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_seed_we |=> !i_req_ready)
        else $error("request side open during reseed");
endmodule

bind xoshiro256ss_random_generator xrg_checker u_xrg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_seed_we   (i_seed_we),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_value (o_rsp.value)
);
`default_nettype wire

FILE: dv/tb_xoshiro256ss_random_generator.sv
// Testbench for xoshiro256ss_random_generator: directed and random requests of
// every kind under several seeds, with idling, stalls and a long result hold-off.
// Depends on xrg_pkg, xrg_req_if, xrg_rsp_if and the generator RTL.
`timescale 1ns / 100ps
module tb_xoshiro256ss_random_generator;
    import xrg_pkg::*;

    localparam logic [1:0] KIND_RAW    = 2'd0;
    localparam logic [1:0] KIND_SPARE  = 2'd3;
    localparam int         CYCLE_LIMIT = 900000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_seed_we = 1'b0;
    logic [63:0] i_seed = '0;

    xrg_req_if req_if ();
    xrg_rsp_if rsp_if ();

    xoshiro256ss_random_generator dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_seed_we (i_seed_we),
        .i_seed    (i_seed),
        .i_req     (req_if.sink),
        .o_rsp     (rsp_if.source)
    );

    logic [63:0] gen_words [4];
    logic [63:0] value_queue [$];
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_cycles = 0;
    int          n_fail = 0;
    int          n_items = 0;
    int          n_results = 0;
    int          n_seeds = 0;
    longint      cycle_count = 0;

    initial begin
        req_if.valid = 1'b0;
        req_if.kind  = '0;
        req_if.bound = '0;
        rsp_if.ready = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rotl64(logic [63:0] v, int k);
        return (v << k) | (v >> (64 - k));
    endfunction

    function automatic void expand_seed(logic [63:0] sv);
        logic [63:0] ctr;
        logic [63:0] z;
        ctr = sv;
        for (int w = 0; w < 4; w++) begin
            ctr = ctr + GOLDEN_INC;
            z = ctr;
            z = (z ^ (z >> 30)) * MIX_MUL_A;
            z = (z ^ (z >> 27)) * MIX_MUL_B;
            gen_words[w] = z ^ (z >> 31);
        end
    endfunction

    function automatic logic [63:0] next_draw();
        logic [63:0] out;
        logic [63:0] shifted;
        out = rotl64(gen_words[1] * 64'd5, 7) * 64'd9;
        shifted = gen_words[1] << 17;
        gen_words[2] ^= gen_words[0];
        gen_words[3] ^= gen_words[1];
        gen_words[1] ^= gen_words[2];
        gen_words[0] ^= gen_words[3];
        gen_words[2] ^= shifted;
        gen_words[3] = rotl64(gen_words[3], 45);
        return out;
    endfunction

    function automatic logic [63:0] predict_value(logic [1:0] kind, logic [63:0] bound);
        logic [63:0] floor_ok;
        logic [63:0] x;
        if (kind == KIND_BOUNDED) begin
            if (bound == 0) return 64'd0;
            floor_ok = (64'd0 - bound) % bound;
            forever begin
                x = next_draw();
                if (x >= floor_ok) return x % bound;
            end
        end
        if (kind == KIND_UNIT) return next_draw() >> 11;
        return next_draw();
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random stalls, optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            n_results++;
            if (value_queue.size() == 0) begin
                $error("value: unexpected result %h", rsp_if.value);
                n_fail++;
            end else begin
                logic [63:0] exp_value;
                exp_value = value_queue.pop_front();
                if (rsp_if.value !== exp_value) begin
                    $error("value: expected %h actual %h", exp_value, rsp_if.value);
                    n_fail++;
                end
            end
        end
    end

    // valid stays high between back-to-back transfers; it drops only while idling or draining
    task automatic send_request(logic [1:0] kind, logic [63:0] bound);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.kind  <= kind;
        req_if.bound <= bound;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        value_queue.push_back(predict_value(kind, bound));
        n_items++;
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (value_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_seed(logic [63:0] sv);
        wait_drained();
        i_seed_we <= 1'b1;
        i_seed    <= sv;
        @(posedge i_clk);
        i_seed_we <= 1'b0;
        expand_seed(sv);
        n_seeds++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] rand_bound();
        case ($urandom_range(5))
            0: return 64'd0;
            1: return 64'($urandom_range(16));
            2: return 64'd1 << $urandom_range(63);
            3: return (64'd1 << 63) + (64'($urandom_range(1000)) << 40);
            default: return rand64() >> $urandom_range(63);
        endcase
    endfunction

    task automatic test_directed();
        send_request(KIND_RAW, 64'd0);
        send_request(KIND_UNIT, '1);
        send_request(KIND_BOUNDED, 64'd0);
        send_request(KIND_BOUNDED, 64'd1);
        send_request(KIND_BOUNDED, 64'd2);
        send_request(KIND_BOUNDED, 64'd3);
        send_request(KIND_BOUNDED, '1);
        send_request(KIND_BOUNDED, 64'h8000_0000_0000_0000);
        send_request(KIND_BOUNDED, 64'h8000_0000_0000_0001);
        send_request(KIND_BOUNDED, 64'hc000_0000_0000_0001);
        send_request(KIND_BOUNDED, 64'h5555_5555_5555_5555);
        send_request(KIND_SPARE, '1);
        send_request(KIND_RAW, 64'haaaa_aaaa_aaaa_aaaa);
        send_request(KIND_UNIT, 64'd0);
    endtask

    task automatic test_random(int count);
        logic [1:0] kind;
        for (int n = 0; n < count; n++) begin
            kind = 2'($urandom_range(3));
            send_request(kind, kind == KIND_BOUNDED ? rand_bound() : rand64());
        end
    endtask

    task automatic test_backpressure();
        @(posedge i_clk);
        hold_cycles <= 400;
        send_idle_pct = 0;
        test_random(12);
    endtask

    initial begin
        expand_seed(64'd0);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_seed('1);
        test_directed();
        write_seed(64'd1);
        test_random(120);
        send_idle_pct = 54;
        write_seed(rand64());
        test_random(110);
        send_idle_pct = 0;
        stall_pct = 54;
        write_seed(rand64());
        test_random(110);
        send_idle_pct = 14;
        stall_pct = 14;
        write_seed(64'h8000_0000_0000_0000);
        test_random(110);
        stall_pct = 0;
        test_backpressure();

        wait_drained();
        $display("Covered %0d requests and %0d results across %0d seed loads.",
                 n_items, n_results, n_seeds + 1);
        if (n_fail == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
